[hw/rtl/cta_pkg.sv]
// cta_pkg: shared types, constants and the restoring divide step for the
// color-to-alpha keying core. no dependencies.
`default_nettype none
package cta_pkg;
  localparam int unsigned PixW = 8;
  localparam int unsigned NumW = 16;
  // one quotient bit per cell, so the chain is as long as the numerator
  localparam int unsigned NumCells = NumW;
  localparam logic [1:0] REG_KEY_RED   = 2'd0;
  localparam logic [1:0] REG_KEY_GREEN = 2'd1;
  localparam logic [1:0] REG_KEY_BLUE  = 2'd2;

  // one pixel in flight through the divider chain
  typedef struct packed {
    logic       valid;
    logic [2:0] neg;     // c below k, per channel
    logic [3:0] num_top; // bit 0: rebuild selected (alpha above one)
    logic [PixW-1:0] k0, k1, k2;
    logic [PixW-1:0] c0, c1, c2;
    logic [PixW-1:0] ain;
  } cta_side_t;

  // one restoring-divide lane state
  typedef struct packed {
    logic [NumW-1:0] rem;
    logic [NumW-1:0] quo;
    logic [NumW-1:0] num;
    logic [NumW-1:0] den;
  } cta_div_t;

  function automatic cta_div_t cta_div_step(input cta_div_t d);
    cta_div_t o;
    logic [NumW:0] r;
    logic [NumW:0] t;
    begin
      o = d;
      r = {d.rem, d.num[NumW-1]};
      t = r - {1'b0, d.den};
      o.num = {d.num[NumW-2:0], 1'b0};
      if (!t[NumW]) begin
        o.rem = t[NumW-1:0];
        o.quo = {d.quo[NumW-2:0], 1'b1};
      end else begin
        o.rem = r[NumW-1:0];
        o.quo = {d.quo[NumW-2:0], 1'b0};
      end
      return o;
    end
  endfunction
endpackage
`default_nettype wire

[hw/rtl/cta_cell.sv]
// cta_cell: one stage of the divider chain, one quotient bit for each lane.
// depends on cta_pkg.
`default_nettype none
module cta_cell #(
  parameter int unsigned Lanes = 3
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire cta_pkg::cta_side_t            side_i,
  input  wire cta_pkg::cta_div_t [Lanes-1:0] lane_i,
  output cta_pkg::cta_side_t                 side_o,
  output cta_pkg::cta_div_t [Lanes-1:0]      lane_o
);
  import cta_pkg::*;
  cta_side_t side_r;
  cta_div_t [Lanes-1:0] lane_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= '0;
    end else if (en) begin
      side_r <= side_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < Lanes; i++) begin
        lane_r[i] <= cta_div_step(lane_i[i]);
      end
    end
  end

  assign side_o = side_r;
  assign lane_o = lane_r;
endmodule
`default_nettype wire

[hw/rtl/cta_chain.sv]
// cta_chain: row of NumCells divide cells, data shifts one cell per cycle while en is high.
// depends on cta_pkg and cta_cell.
`default_nettype none
module cta_chain #(
  parameter int unsigned Lanes = 3
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire cta_pkg::cta_side_t            side_i,
  input  wire cta_pkg::cta_div_t [Lanes-1:0] lane_i,
  output cta_pkg::cta_side_t                 side_o,
  output cta_pkg::cta_div_t [Lanes-1:0]      lane_o
);
  import cta_pkg::*;
  cta_side_t side_w [NumCells+1];
  cta_div_t [Lanes-1:0] lane_w [NumCells+1];

  assign side_w[0] = side_i;
  assign lane_w[0] = lane_i;
  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    cta_cell #(.Lanes(Lanes)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .side_i(side_w[g]), .lane_i(lane_w[g]),
      .side_o(side_w[g+1]), .lane_o(lane_w[g+1])
    );
  end
  assign side_o = side_w[NumCells];
  assign lane_o = lane_w[NumCells];
endmodule
`default_nettype wire

[hw/rtl/colour_to_alpha_pixel_core.sv]
// colour_to_alpha_pixel_core: color keying top level, two divider chains.
// depends on cta_pkg, cta_chain, cta_cell.
//
//  channel | ports                              | direction
//  in      | in_valid in_stall in_red..in_alpha | into core
//  out     | out_valid out_stall out_red..alpha | out of core
//  cfg     | cfg_we cfg_index cfg_data          | into core
//
// one pixel per cycle sustained while out_stall does not hold the pipe; a
// pixel passes the 16-cell restoring alpha chain, the max register, the
// 16-cell restoring rebuild chain and then the output register.
// reset clears valid bits and keys. the whole pipe advances together;
// out_stall with a full output register freezes it and raises in_stall.
`default_nettype none
module colour_to_alpha_pixel_core (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [cta_pkg::PixW-1:0]  in_red,
  input  wire logic [cta_pkg::PixW-1:0]  in_green,
  input  wire logic [cta_pkg::PixW-1:0]  in_blue,
  input  wire logic [cta_pkg::PixW-1:0]  in_alpha,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [cta_pkg::PixW-1:0]       out_red,
  output logic [cta_pkg::PixW-1:0]       out_green,
  output logic [cta_pkg::PixW-1:0]       out_blue,
  output logic [cta_pkg::PixW-1:0]       out_alpha,
  input  wire logic                      cfg_we,
  input  wire logic [1:0]                cfg_index,
  input  wire logic [cta_pkg::PixW-1:0]  cfg_data
);
  import cta_pkg::*;

  logic [PixW-1:0] key_red_r, key_green_r, key_blue_r;
  logic en;

  // key registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_red_r <= '0; key_green_r <= '0; key_blue_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY_RED:   key_red_r <= cfg_data;
        REG_KEY_GREEN: key_green_r <= cfg_data;
        REG_KEY_BLUE:  key_blue_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipe moves unless the output register holds a stalled transaction
  assign en = !(out_valid && out_stall);
  assign in_stall = !en;

  // stage a: per channel numerator 255*|c-k| and divisor
  cta_side_t side_a;
  cta_div_t [2:0] lane_a;
  logic [PixW-1:0] cv [3];
  logic [PixW-1:0] kv [3];
  always_comb begin
    cv[0] = in_red; cv[1] = in_green; cv[2] = in_blue;
    kv[0] = key_red_r; kv[1] = key_green_r; kv[2] = key_blue_r;
    side_a = '0;
    side_a.valid = in_valid;
    side_a.k0 = kv[0]; side_a.k1 = kv[1]; side_a.k2 = kv[2];
    side_a.c0 = cv[0]; side_a.c1 = cv[1]; side_a.c2 = cv[2];
    side_a.ain = in_alpha;
    for (int i = 0; i < 3; i++) begin
      lane_a[i].rem = '0;
      lane_a[i].quo = '0;
      if (cv[i] > kv[i]) begin
        lane_a[i].num = NumW'(16'd255 * NumW'(cv[i] - kv[i]));
        lane_a[i].den = NumW'(8'd255 - kv[i]);
      end else if (cv[i] < kv[i]) begin
        lane_a[i].num = NumW'(16'd255 * NumW'(kv[i] - cv[i]));
        lane_a[i].den = NumW'(kv[i]);
      end else begin
        lane_a[i].num = '0;
        lane_a[i].den = NumW'(1);
      end
    end
  end

  cta_side_t side_b;
  cta_div_t [2:0] lane_b;
  cta_chain #(.Lanes(3)) u_alpha_chain (
    .clk(clk), .rst_n(rst_n), .en(en),
    .side_i(side_a), .lane_i(lane_a), .side_o(side_b), .lane_o(lane_b)
  );

  // max of channel alphas, registered
  logic [PixW-1:0] amax_nxt, amax_r;
  cta_side_t side_c_r;
  always_comb begin
    amax_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      if (lane_b[i].quo[PixW-1:0] > amax_nxt) amax_nxt = lane_b[i].quo[PixW-1:0];
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_c_r <= '0;
    end else if (en) begin
      side_c_r <= side_b;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      amax_r <= amax_nxt;
    end
  end

  // stage d: 255*|c-k| / a per channel
  cta_side_t side_d;
  cta_div_t [2:0] lane_d;
  logic [PixW-1:0] cc [3];
  logic [PixW-1:0] kk [3];
  logic [PixW-1:0] adiv;
  always_comb begin
    cc[0] = side_c_r.c0; cc[1] = side_c_r.c1; cc[2] = side_c_r.c2;
    kk[0] = side_c_r.k0; kk[1] = side_c_r.k1; kk[2] = side_c_r.k2;
    adiv = (amax_r > 8'd1) ? amax_r : 8'd2;
    side_d = side_c_r;
    side_d.num_top = {3'b000, amax_r > 8'd1};
    for (int i = 0; i < 3; i++) begin
      side_d.neg[i] = cc[i] < kk[i];
      lane_d[i].rem = '0;
      lane_d[i].quo = '0;
      lane_d[i].num = (cc[i] < kk[i]) ? NumW'(16'd255 * NumW'(kk[i] - cc[i]))
                                      : NumW'(16'd255 * NumW'(cc[i] - kk[i]));
      lane_d[i].den = NumW'(adiv);
    end
  end

  // the keyed alpha amax_r rides a shift line beside the rebuild chain, for the
  // pass-through case and for the a*ain/255 scaling at the end
  logic [PixW-1:0] amax_line_r [NumCells];
  always_ff @(posedge clk) begin
    if (en) begin
      amax_line_r[0] <= amax_r;
      for (int i = 1; i < NumCells; i++) amax_line_r[i] <= amax_line_r[i-1];
    end
  end

  cta_side_t side_e;
  cta_div_t [2:0] lane_e;
  cta_chain #(.Lanes(3)) u_rebuild_chain (
    .clk(clk), .rst_n(rst_n), .en(en),
    .side_i(side_d), .lane_i(lane_d), .side_o(side_e), .lane_o(lane_e)
  );

  // final: add key, clamp, select pass-through, scale alpha, output register
  logic [PixW-1:0] res_nxt [4];
  logic [PixW-1:0] ce [3];
  logic [PixW-1:0] ke [3];
  logic signed [NumW+1:0] v;
  logic [NumW-1:0] aprod, asum;
  always_comb begin
    ce[0] = side_e.c0; ce[1] = side_e.c1; ce[2] = side_e.c2;
    ke[0] = side_e.k0; ke[1] = side_e.k1; ke[2] = side_e.k2;
    v = '0;
    for (int i = 0; i < 3; i++) begin
      if (side_e.neg[i]) v = $signed({2'b00, NumW'(ke[i])}) - $signed({2'b00, lane_e[i].quo});
      else v = $signed({2'b00, NumW'(ke[i])}) + $signed({2'b00, lane_e[i].quo});
      if (!side_e.num_top[0]) res_nxt[i] = ce[i];
      else if (v < 0) res_nxt[i] = '0;
      else if (v > 255) res_nxt[i] = 8'd255;
      else res_nxt[i] = v[PixW-1:0];
    end
    // a*ain/255 by add and shift, exact for products up to 255*255
    aprod = NumW'(amax_line_r[NumCells-1]) * NumW'(side_e.ain);
    asum = aprod + (aprod >> 8) + NumW'(1);
    res_nxt[3] = side_e.num_top[0] ? asum[NumW-1:PixW] : amax_line_r[NumCells-1];
  end

  logic out_valid_r;
  logic [PixW-1:0] out_r [4];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= side_e.valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) out_r[i] <= res_nxt[i];
    end
  end
  assign out_valid = out_valid_r;
  assign out_red = out_r[0];
  assign out_green = out_r[1];
  assign out_blue = out_r[2];
  assign out_alpha = out_r[3];

  // stalled output must keep out_valid and not change out_alpha
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_alpha))
    else $error("output changed under stall");
  // input stall only when output is blocked
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("spurious input stall");
  // pass-through alpha never exceeds one
  a_pass: assert property (@(posedge clk) disable iff (!rst_n)
    en && side_e.valid && !side_e.num_top[0] |-> amax_line_r[NumCells-1] <= 8'd1)
    else $error("pass-through with large alpha");
endmodule
`default_nettype wire
